// ===== rtl/iida_pkg.sv =====
// Shared types and constants for the indexed insert/delete array.
package iida_pkg;

    // Default sizing of the storage
    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_ELEMENT_WIDTH = 32;

    // Fixed field widths of the beats
    localparam int INDEX_W = 6;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Operation codes
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_APPEND = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Input beat
    typedef struct packed {
        t_op                        operation;
        logic [INDEX_W-1:0]         index;
        logic signed [VALUE_W-1:0]  value;
    } t_in;

    // Result beat
    typedef struct packed {
        t_status                    status;
        logic [COUNT_W-1:0]         count;
        logic signed [VALUE_W-1:0]  read_value;
    } t_out;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESP
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture an accepted beat
        logic latch_st;  // latch the operation status
        logic mem_we;    // write memory at the pointer
        logic wr_val;    // write data is the beat value, else the moved entry
        logic ptr_step;  // advance the shift pointer
        logic cnt_inc;
        logic cnt_dec;
    } t_ctl;

    // Status from datapath to controller
    typedef struct packed {
        t_op     op;
        t_status st;
        logic    shift;  // another entry still has to move
    } t_flag;

endpackage

// ===== rtl/iida_datapath.sv =====
// Storage, count, shift pointer and result formatting of the insert/delete array.
module iida_datapath #(
    parameter int CAPACITY      = iida_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = iida_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iida_pkg::t_in   i_item,
    input  iida_pkg::t_ctl  i_ctl,
    output iida_pkg::t_flag o_flag,
    output iida_pkg::t_out  o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = (CW > iida_pkg::COUNT_W) ? CW : iida_pkg::COUNT_W;

    logic [ELEMENT_WIDTH-1:0] r_mem [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] r_q;
    logic [ELEMENT_WIDTH-1:0] r_val;
    logic [ELEMENT_WIDTH-1:0] wr_data;
    iida_pkg::t_op            r_op;
    iida_pkg::t_status        r_status;
    iida_pkg::t_status        st;
    logic [KW-1:0]            r_idx;
    logic [AW-1:0]            r_ptr;
    logic [AW-1:0]            rd_addr;
    logic [CW-1:0]            r_count;
    logic [KW-1:0]            cnt_k;
    logic [KW-1:0]            ptr_k;
    logic                     shift;
    logic signed [63:0]       val_ext;
    logic signed [63:0]       q_ext;

    assign cnt_k   = KW'(r_count);
    assign ptr_k   = KW'(r_ptr);
    assign val_ext = 64'(i_item.value);
    assign q_ext   = 64'(signed'(r_q));

    // Capture the beat (append becomes insert at the current count), or step the shift pointer
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= val_ext[ELEMENT_WIDTH-1:0];
            if (i_item.operation == iida_pkg::OP_APPEND) begin
                r_op  <= iida_pkg::OP_INSERT;
                r_idx <= cnt_k;
                r_ptr <= r_count[AW-1:0];
            end else begin
                r_op  <= i_item.operation;
                r_idx <= KW'(i_item.index);
                if (i_item.operation == iida_pkg::OP_INSERT) begin
                    r_ptr <= r_count[AW-1:0];
                end else begin
                    r_ptr <= AW'(i_item.index);
                end
            end
        end else if (i_ctl.ptr_step) begin
            if (r_op == iida_pkg::OP_INSERT) begin
                r_ptr <= r_ptr - AW'(1);
            end else begin
                r_ptr <= r_ptr + AW'(1);
            end
        end
    end

    // Operation status from the captured beat and the count
    always_comb begin
        st = iida_pkg::ST_DONE;
        if (r_op == iida_pkg::OP_INSERT) begin
            if (r_idx > cnt_k) begin
                st = iida_pkg::ST_RANGE;
            end else if (cnt_k >= KW'(CAPACITY)) begin
                st = iida_pkg::ST_FULL;
            end
        end else if (r_idx >= cnt_k) begin
            st = iida_pkg::ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch_st) begin
            r_status <= st;
        end
    end

    // Shift continues while the pointer has not reached its end
    always_comb begin
        if (r_op == iida_pkg::OP_INSERT) begin
            shift = ptr_k > r_idx;
        end else begin
            shift = (ptr_k + KW'(1)) < cnt_k;
        end
    end

    // Read address: source of the next move, or the pointer for a read
    always_comb begin
        case (r_op)
            iida_pkg::OP_INSERT: rd_addr = r_ptr - AW'(1);
            iida_pkg::OP_DELETE: rd_addr = r_ptr + AW'(1);
            default:             rd_addr = r_ptr;
        endcase
    end

    assign wr_data = i_ctl.wr_val ? r_val : r_q;

    // Element memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.mem_we) begin
            r_mem[r_ptr] <= wr_data;
        end
        r_q <= r_mem[rd_addr];
    end

    // Element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.cnt_inc) begin
            r_count <= r_count + CW'(1);
        end else if (i_ctl.cnt_dec) begin
            r_count <= r_count - CW'(1);
        end
    end

    assign o_flag.op    = r_op;
    assign o_flag.st    = st;
    assign o_flag.shift = shift;

    // Result beat
    assign o_result.status     = r_status;
    assign o_result.count      = iida_pkg::COUNT_W'(r_count);
    assign o_result.read_value = (r_op == iida_pkg::OP_READ && r_status == iida_pkg::ST_DONE)
                               ? q_ext[iida_pkg::VALUE_W-1:0] : '0;

endmodule

// ===== rtl/iida_ctrl.sv =====
// Sequencing state machine of the insert/delete array.
module iida_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  iida_pkg::t_flag i_flag,
    output logic            busy,
    output logic            o_done,
    output iida_pkg::t_ctl  o_ctl
);

    iida_pkg::t_state r_state;
    iida_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iida_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            iida_pkg::S_IDLE: begin
                if (start) begin
                    n_state = iida_pkg::S_CHECK;
                end
            end
            iida_pkg::S_CHECK: begin
                if (i_flag.st != iida_pkg::ST_DONE || i_flag.op == iida_pkg::OP_READ) begin
                    n_state = iida_pkg::S_RESP;
                end else begin
                    n_state = iida_pkg::S_SHIFT_RD;
                end
            end
            iida_pkg::S_SHIFT_RD: begin
                if (i_flag.shift) begin
                    n_state = iida_pkg::S_SHIFT_WR;
                end else begin
                    n_state = iida_pkg::S_RESP;
                end
            end
            iida_pkg::S_SHIFT_WR: n_state = iida_pkg::S_SHIFT_RD;
            iida_pkg::S_RESP:     n_state = iida_pkg::S_IDLE;
            default:              n_state = iida_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        o_ctl  = '0;
        busy   = 1'b1;
        o_done = 1'b0;
        case (r_state)
            iida_pkg::S_IDLE: begin
                busy       = 1'b0;
                o_ctl.load = start;
            end
            iida_pkg::S_CHECK: begin
                o_ctl.latch_st = 1'b1;
            end
            iida_pkg::S_SHIFT_RD: begin
                // no more moves: place the value or drop the last entry
                if (!i_flag.shift) begin
                    if (i_flag.op == iida_pkg::OP_INSERT) begin
                        o_ctl.mem_we  = 1'b1;
                        o_ctl.wr_val  = 1'b1;
                        o_ctl.cnt_inc = 1'b1;
                    end else begin
                        o_ctl.cnt_dec = 1'b1;
                    end
                end
            end
            iida_pkg::S_SHIFT_WR: begin
                o_ctl.mem_we   = 1'b1;
                o_ctl.ptr_step = 1'b1;
            end
            iida_pkg::S_RESP: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/indexed_insert_delete_array.sv =====
// Top level of the indexed insert/delete array.
//
// Usage: an ordered list of up to CAPACITY signed words with a count.
// A command beat (operation, index, value) is taken at a rising edge with
// start high and busy low; busy stays high until the result is shown.
// Each command gives one result beat on o_result, marked by o_done for
// exactly one cycle; the receiver must take it then, it cannot stall.
// Insert and delete move each stored entry through the element memory
// (one read, then one write of the moved word).
// From accept to o_done, a read or a rejected command passes the check
// and response states; insert/append/delete add a read and write state
// per entry shifted (at most count - index) and a final read state.
// A new command may be started in the cycle after o_done.
// Reset (synchronous, active low) empties the list; the memory contents
// are not cleared, and only entries below the count are ever used.
module indexed_insert_delete_array #(
    parameter int CAPACITY      = iida_pkg::DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = iida_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  iida_pkg::t_in  i_item,
    output logic           o_done,
    output iida_pkg::t_out o_result
);

    iida_pkg::t_ctl  ctl;
    iida_pkg::t_flag flag;

    iida_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flag  (flag),
        .busy    (busy),
        .o_done  (o_done),
        .o_ctl   (ctl)
    );

    iida_datapath #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_flag   (flag),
        .o_result (o_result)
    );

endmodule

// ===== tb/iida_checker.sv =====
`timescale 1ns / 100ps
// Beat monitor, list predictor and result scoreboard for the insert/delete array.
module iida_checker
    import iida_pkg::*;
#(
    parameter int CAPACITY      = DEF_CAPACITY,
    parameter int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  logic busy,
    input  t_in  i_item,
    input  logic o_done,
    input  t_out o_result,
    output int   o_fail_count,
    output int   o_pending
);

    // Shadow copy of the list and its length
    logic [ELEMENT_WIDTH-1:0] shadow_list [CAPACITY];
    int unsigned              shadow_len;
    t_out                     result_fifo [$];
    int                       mismatch_cnt;

    // Apply one command to the shadow list and return the result beat it gives
    function automatic t_out apply_list_op(input t_in cmd);
        t_out        res;
        int unsigned pos;
        logic [63:0] wide;
        res.status     = ST_DONE;
        res.read_value = '0;
        pos            = cmd.index;
        if (cmd.operation == OP_APPEND)
            pos = shadow_len;
        case (cmd.operation)
            OP_INSERT, OP_APPEND: begin
                if (pos > shadow_len) begin
                    res.status = ST_RANGE;
                end else if (shadow_len >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = shadow_len; i > pos; i--)
                        shadow_list[i] = shadow_list[i-1];
                    wide             = 64'(cmd.value);
                    shadow_list[pos] = wide[ELEMENT_WIDTH-1:0];
                    shadow_len++;
                end
            end
            OP_DELETE: begin
                if (pos >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                end
            end
            default: begin
                if (pos >= shadow_len) begin
                    res.status = ST_RANGE;
                end else begin
                    // stored word is sign-extended back to the beat width
                    wide           = 64'($signed(shadow_list[pos]));
                    res.read_value = wide[VALUE_W-1:0];
                end
            end
        endcase
        res.count = shadow_len[COUNT_W-1:0];
        return res;
    endfunction

    // Sample both channels at each edge; results checked before new beats land
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            shadow_len   = 0;
            mismatch_cnt = 0;
            result_fifo.delete();
        end else begin
            if (o_done) begin
                if (result_fifo.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, o_result);
                    mismatch_cnt++;
                end else begin
                    want = result_fifo.pop_front();
                    if (o_result.status !== want.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, o_result.status);
                        mismatch_cnt++;
                    end
                    if (o_result.count !== want.count) begin
                        $display("%0t: count mismatch expected %0d actual %0d",
                                 $time, want.count, o_result.count);
                        mismatch_cnt++;
                    end
                    if (o_result.read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch expected %h actual %h",
                                 $time, want.read_value, o_result.read_value);
                        mismatch_cnt++;
                    end
                end
            end
            if (start && !busy)
                result_fifo.push_back(apply_list_op(i_item));
        end
        o_fail_count = mismatch_cnt;
        o_pending    = result_fifo.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the insert/delete array testbench: clock, reset, command stimulus, verdict.
module tb;
    import iida_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int ELEMENT_WIDTH = DEF_ELEMENT_WIDTH;
    localparam int RAND_ITEMS    = 2000;
    localparam int STALL_LIMIT   = 5000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_item;
    logic o_done;
    t_out o_result;
    int   fail_count;
    int   pending_cnt;

    // Stimulus-side tracking of the list length and sender idle rate
    int   list_len;
    int   idle_pct;
    int   stall_cycles;

    indexed_insert_delete_array #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    iida_checker #(
        .CAPACITY      (CAPACITY),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_done       (o_done),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Present one command beat after a random idle gap; returns at the accepting edge
    task automatic issue_cmd(input t_op op, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val);
        t_in cmd;
        int  gap;
        cmd.operation = op;
        cmd.index     = idx;
        cmd.value     = val;
        case (op)
            OP_INSERT: if (idx <= list_len && list_len < CAPACITY) list_len++;
            OP_APPEND: if (list_len < CAPACITY) list_len++;
            OP_DELETE: if (idx < list_len) list_len--;
            default: ;
        endcase
        gap = 0;
        while ($urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Mostly random words, now and then a boundary value
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // Watchdog on cycles with no beat moving in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int               mode;
        int               mode_left;
        int               roll;
        int               ins_w;
        int               app_w;
        int               del_w;
        t_op              op;
        logic [INDEX_W-1:0] idx;

        i_rst_n  <= 1'b0;
        start    <= 1'b0;
        i_item   <= '0;
        list_len  = 0;
        idle_pct  = 28;
        mode      = 0;
        mode_left = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list rejects, boundary values, out-of-range indices
        issue_cmd(OP_READ,   6'd0,  pick_value());
        issue_cmd(OP_DELETE, 6'd0,  32'h0);
        issue_cmd(OP_DELETE, 6'd63, 32'h0);
        issue_cmd(OP_INSERT, 6'd1,  32'h1111_1111);
        issue_cmd(OP_INSERT, 6'd0,  32'h7FFF_FFFF);
        issue_cmd(OP_APPEND, 6'd63, 32'h8000_0000);
        issue_cmd(OP_APPEND, 6'd0,  32'h0000_0000);
        issue_cmd(OP_INSERT, 6'd1,  32'hFFFF_FFFF);
        issue_cmd(OP_INSERT, 6'd4,  32'h1234_5678);
        issue_cmd(OP_INSERT, 6'd63, 32'h5A5A_5A5A);
        for (int i = 0; i < 6; i++)
            issue_cmd(OP_READ, INDEX_W'(i), 32'hFFFF_FFFF);
        issue_cmd(OP_DELETE, 6'd1,  32'hFFFF_FFFF);
        issue_cmd(OP_DELETE, 6'd3,  32'h0);
        issue_cmd(OP_READ,   6'd63, 32'h0);

        // Fill to capacity, then hit the full list at both index extremes
        while (list_len < CAPACITY)
            issue_cmd(OP_APPEND, INDEX_W'($urandom_range(63)), pick_value());
        issue_cmd(OP_APPEND, 6'd0,  32'hDEAD_BEEF);
        issue_cmd(OP_INSERT, 6'd0,  32'hDEAD_BEEF);
        issue_cmd(OP_INSERT, 6'd63, 32'hDEAD_BEEF);
        issue_cmd(OP_READ,   6'd63, 32'h0);
        issue_cmd(OP_DELETE, 6'd0,  32'h0);
        issue_cmd(OP_INSERT, 6'd0,  32'h8000_0000);
        issue_cmd(OP_READ,   6'd0,  32'h0);
        issue_cmd(OP_READ,   6'd63, 32'h0);

        // Random: phases that grow, shrink or hold the list, mostly legal indices
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3)
                idle_pct = 46;
            if (n == 2 * RAND_ITEMS / 3)
                idle_pct = 0;
            if (mode_left == 0) begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(200, 64);
            end
            mode_left--;
            case (mode)
                0: begin ins_w = 35; app_w = 30; del_w = 10; end
                1: begin ins_w = 10; app_w = 10; del_w = 50; end
                default: begin ins_w = 20; app_w = 15; del_w = 35; end
            endcase
            roll = $urandom_range(99);
            if (roll < ins_w)
                op = OP_INSERT;
            else if (roll < ins_w + app_w)
                op = OP_APPEND;
            else if (roll < ins_w + app_w + del_w)
                op = OP_DELETE;
            else
                op = OP_READ;
            if ($urandom_range(99) < 12 || op == OP_APPEND)
                idx = INDEX_W'($urandom_range(63));
            else if (op == OP_INSERT)
                idx = INDEX_W'($urandom_range(list_len > 63 ? 63 : list_len));
            else
                idx = (list_len == 0) ? '0 : INDEX_W'($urandom_range(list_len - 1));
            issue_cmd(op, idx, pick_value());
        end
        start <= 1'b0;

        // Drain outstanding results, then a short tail
        @(posedge i_clk);
        while (pending_cnt != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && pending_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/iida_pkg.sv
rtl/iida_datapath.sv
rtl/iida_ctrl.sv
rtl/indexed_insert_delete_array.sv
tb/iida_checker.sv
tb/tb.sv
